@@ src/ipv4tv_pkg.sv @@
// shared types and constants for the ipv4 text validator
`timescale 1ns / 1ps

package ipv4tv_pkg;

  localparam logic [7:0] ChSpace    = 8'd32;
  localparam logic [7:0] ChDot      = 8'd46;
  localparam logic [7:0] ChZero     = 8'd48;
  localparam logic [7:0] ChNine     = 8'd57;
  localparam logic [11:0] OctetMax  = 12'd255;
  localparam logic [2:0] DotsNeeded = 3'd3;
  localparam logic [2:0] DotSat     = 3'd4;

  typedef struct packed {
    logic [7:0] octet;
    logic [2:0] dots;
    logic       failed;
    logic       prev_space;
  } line_state_t;

endpackage

@@ src/ipv4tv_step.sv @@
// per-character update of the line state and the pass decision
`timescale 1ns / 1ps

module ipv4tv_step (
  input  ipv4tv_pkg::line_state_t st_i,
  input  logic [7:0]              ch_i,
  input  logic                    last_i,
  output ipv4tv_pkg::line_state_t st_o,
  output logic                    pass_o
);

  logic                    is_space;
  logic                    is_dot;
  logic                    is_digit;
  logic [11:0]             next_octet;
  ipv4tv_pkg::line_state_t upd;

  assign is_space = (ch_i == ipv4tv_pkg::ChSpace);
  assign is_dot   = (ch_i == ipv4tv_pkg::ChDot);
  assign is_digit = ch_i inside {[ipv4tv_pkg::ChZero:ipv4tv_pkg::ChNine]};

  // octet * 10 + digit as two shifts and adds
  assign next_octet = {1'b0, st_i.octet, 3'b000} + {3'b000, st_i.octet, 1'b0}
                    + {8'd0, ch_i[3:0]};

  always_comb begin
    upd = st_i;
    if (is_space) begin
      if (st_i.prev_space || last_i) begin
        upd.failed = 1'b1;
      end
    end else if (is_dot) begin
      if (last_i) begin
        upd.failed = 1'b1;
      end
      upd.octet = 8'd0;
      if (st_i.dots < ipv4tv_pkg::DotSat) begin
        upd.dots = st_i.dots + 3'd1;
      end
    end else if (is_digit) begin
      if (next_octet > ipv4tv_pkg::OctetMax) begin
        upd.failed = 1'b1;
      end else begin
        upd.octet = next_octet[7:0];
      end
    end else begin
      upd.failed = 1'b1;
    end
    upd.prev_space = is_space;
  end

  assign pass_o = !upd.failed && (upd.dots == ipv4tv_pkg::DotsNeeded);
  // a line end returns everything to the cleared state
  assign st_o   = last_i ? '0 : upd;

endmodule

@@ src/ipv4_text_validator_top.sv @@
// top level of the ipv4 dotted-decimal line validator
// result: a line's result is registered in the output slot as its last beat advances
// out of the input register, when the output slot is free
// throughput: one character beat per cycle, set by the combinational state update
// the input register keeps taking beats while a finished result waits downstream,
// until the next final beat reaches it and waits for the output slot
// reset: asynchronous active-low, clears line state and both valid flags
`timescale 1ns / 1ps

module ipv4_text_validator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);

  logic                    in_valid_q;
  logic [7:0]              ch_q;
  logic                    last_q;
  ipv4tv_pkg::line_state_t st_q;
  ipv4tv_pkg::line_state_t st_d;
  logic                    pass;
  logic                    out_valid_q;
  logic                    valid_res_q;
  logic                    adv;
  logic                    in_fire;

  // a non-final beat never needs the output slot
  assign adv        = in_valid_q && (!last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;
  assign in_fire    = in_valid_i && in_ready_o;

  ipv4tv_step u_step (
    .st_i   (st_q),
    .ch_i   (ch_q),
    .last_i (last_q),
    .st_o   (st_d),
    .pass_o (pass)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ch_q   <= ch_i;
      last_q <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      valid_res_q <= pass;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = valid_res_q;

`ifndef SYNTHESIS
  a_dots_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.dots <= ipv4tv_pkg::DotSat)
    else $error("dot count above saturation");

  a_clear_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> st_q == '0)
    else $error("line state not cleared after final beat");

  a_result_after_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> out_valid_q)
    else $error("final beat produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(adv && last_q))
    else $error("pending result overwritten");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |-> !in_ready_o)
    else $error("input register accepts while stalled");
`endif

endmodule
